FILE: rtl/core/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, constants and the CRC-8 step for the sensor frame decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    // CRC-8, polynomial 0x31, MSB first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Bytes 0..5 carry data, byte 6 carries the CRC
    localparam int unsigned DATA_BYTES = 6;
    localparam int unsigned POS_W      = 3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W      = 1;
    localparam int unsigned CFG_DATA_W       = 15;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_GAIN    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_OFFSET = 1'd1;

    localparam int unsigned GAIN_W   = 15;
    localparam int unsigned OFFSET_W = 13;
    localparam logic [GAIN_W-1:0]          HUM_GAIN_RESET    = 15'd16384;
    localparam logic signed [OFFSET_W-1:0] TEMP_OFFSET_RESET = 13'sd0;

    // Scaling constants: hum = raw*100*gain >> 26, temp = (raw*200 >> 12) - 50 degC
    localparam int unsigned RAW_W      = 20;
    localparam int unsigned HUM_P1_W   = 27;
    localparam int unsigned HUM_P2_W   = HUM_P1_W + GAIN_W;
    localparam int unsigned TMP_P1_W   = 28;
    localparam int unsigned HUM_SHIFT  = 26;
    localparam int unsigned TMP_SHIFT  = 12;
    localparam int unsigned HUM_Q8_W   = 16;
    localparam int unsigned TMP_Q8_W   = 17;
    localparam int unsigned HUM_SCALE  = 100;
    localparam int unsigned TMP_SCALE  = 200;
    localparam int unsigned TMP_BIAS   = 12800;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0]       status_byte;
        logic             crc_match;
        logic [RAW_W-1:0] humidity_raw;
        logic [RAW_W-1:0] raw_temperature;
    } frame_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] crc;
        crc = crc_in ^ data_in;
        for (int k = 0; k < 8; k++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/sensor_frame_crc_decode_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_decode_core
// Decodes a seven-byte humidity/temperature sensor frame with CRC-8 check.
// ----------------------------------------------------------------------------
// Feed the frame one byte per item, with s_frame_start high on byte 0; a
// start byte always restarts collection, and a byte without a frame in
// progress is dropped. The collector takes one byte per cycle while s_ready
// is high and runs the CRC-8 (poly 0x31, init 0xFF) over bytes 0..5. On
// byte 6 it queues the frame; the scaling engine then handles one frame at a
// time (queue pop, two registered multiply steps, result load) and raises
// m_valid when it loads the result register, which waits for the output to
// be free. The frame queue (QUEUE_DEPTH entries) lets the collector keep taking
// bytes while the engine or the consumer stalls; s_ready drops only when it
// is full. Results: status byte, CRC match flag, the two raw 20-bit fields,
// humidity in Q8 (gain applied, floor) and signed temperature in Q8 (offset
// applied). Write configuration only while no frame is in flight.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decode_core #(
    parameter int unsigned QUEUE_DEPTH = sfcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // byte input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_rx_byte,
    input  logic                                  s_frame_start,
    // frame result
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [7:0]                            m_status_byte,
    output logic                                  m_crc_match,
    output logic [sfcd_pkg::RAW_W-1:0]            m_humidity_raw,
    output logic [sfcd_pkg::RAW_W-1:0]            m_raw_temperature,
    output logic [sfcd_pkg::HUM_Q8_W-1:0]         m_humidity_q8,
    output logic signed [sfcd_pkg::TMP_Q8_W-1:0]  m_temperature_q8,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [sfcd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sfcd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    logic                                  s_accept;
    logic                                  q_push;
    sfcd_pkg::frame_t                      q_push_frame;
    logic                                  q_pop;
    sfcd_pkg::frame_t                      q_pop_frame;
    logic                                  q_full;
    logic                                  q_empty;

    logic [sfcd_pkg::GAIN_W-1:0]           hum_gain_reg;
    logic signed [sfcd_pkg::OFFSET_W-1:0]  temp_offset_reg;

    // Hold bytes only when the queue cannot take a finished frame
    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    // Configuration registers; other indexes do nothing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hum_gain_reg    <= sfcd_pkg::HUM_GAIN_RESET;
            temp_offset_reg <= sfcd_pkg::TEMP_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sfcd_pkg::REG_HUM_GAIN:
                    hum_gain_reg <= cfg_wdata[sfcd_pkg::GAIN_W-1:0];
                sfcd_pkg::REG_TEMP_OFFSET:
                    temp_offset_reg <= $signed(cfg_wdata[sfcd_pkg::OFFSET_W-1:0]);
                default: ;
            endcase
        end
    end

    // Front: collect bytes, run the CRC, emit one frame per CRC byte
    sfcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .rx_byte     (s_rx_byte),
        .frame_start (s_frame_start),
        .push        (q_push),
        .push_frame  (q_push_frame)
    );

    // Decouple collector and scaling engine
    sfcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_frame (q_push_frame),
        .pop        (q_pop),
        .pop_frame  (q_pop_frame),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Back: scale the raw fields and drive the result register
    sfcd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (!q_empty),
        .q_frame           (q_pop_frame),
        .q_pop             (q_pop),
        .hum_gain          (hum_gain_reg),
        .temp_offset       (temp_offset_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status_byte     (m_status_byte),
        .m_crc_match       (m_crc_match),
        .m_humidity_raw    (m_humidity_raw),
        .m_raw_temperature (m_raw_temperature),
        .m_humidity_q8     (m_humidity_q8),
        .m_temperature_q8  (m_temperature_q8)
    );

    // A frame enters the queue only on an accepted byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> s_accept)
        else $error("frame pushed without an accepted byte");

    // The engine never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty frame queue");

    // A frame pushed into an empty queue is visible on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_empty) |=> !q_empty)
        else $error("pushed frame lost");

endmodule

FILE: rtl/core/sfcd_front.sv
// ----------------------------------------------------------------------------
// sfcd_front
// Byte collector: tracks frame position, runs the CRC and packs a frame.
// ----------------------------------------------------------------------------
module sfcd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                push,
    output sfcd_pkg::frame_t    push_frame
);

    logic [sfcd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                 crc_reg, crc_next;
    logic [47:0]                coll_reg, coll_next;

    logic [sfcd_pkg::POS_W-1:0] pos_eff;
    logic [7:0]                 crc_eff;
    logic [47:0]                coll_eff;

    always_comb begin
        // a start byte discards any partial frame
        pos_eff  = frame_start ? '0 : pos_reg;
        crc_eff  = frame_start ? sfcd_pkg::CRC_INIT : crc_reg;
        coll_eff = frame_start ? '0 : coll_reg;

        pos_next   = pos_reg;
        crc_next   = crc_reg;
        coll_next  = coll_reg;
        push       = 1'b0;

        push_frame.status_byte     = coll_reg[47:40];
        push_frame.crc_match       = (crc_reg == rx_byte);
        push_frame.humidity_raw    = coll_reg[39:20];
        push_frame.raw_temperature = coll_reg[19:0];

        if (accept && (frame_start || (pos_reg != '0))) begin
            if (pos_eff < sfcd_pkg::POS_W'(sfcd_pkg::DATA_BYTES)) begin
                crc_next  = sfcd_pkg::crc8_update(crc_eff, rx_byte);
                coll_next = {coll_eff[39:0], rx_byte};
                pos_next  = pos_eff + 1'b1;
            end else begin
                // CRC byte: hand the frame on, return to idle
                push      = 1'b1;
                pos_next  = '0;
                crc_next  = sfcd_pkg::CRC_INIT;
                coll_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            crc_reg  <= sfcd_pkg::CRC_INIT;
            coll_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            coll_reg <= coll_next;
        end
    end

endmodule

FILE: rtl/core/sfcd_queue.sv
// ----------------------------------------------------------------------------
// sfcd_queue
// Small frame queue between the collector and the scaling engine.
// ----------------------------------------------------------------------------
module sfcd_queue #(
    parameter int unsigned DEPTH = sfcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sfcd_pkg::frame_t push_frame,
    input  logic             pop,
    output sfcd_pkg::frame_t pop_frame,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sfcd_pkg::frame_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_frame = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

FILE: rtl/core/sfcd_back.sv
// ----------------------------------------------------------------------------
// sfcd_back
// Scaling engine: two multiply steps per frame, then the result register.
// ----------------------------------------------------------------------------
module sfcd_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_valid,
    input  sfcd_pkg::frame_t                      q_frame,
    output logic                                  q_pop,
    input  logic [sfcd_pkg::GAIN_W-1:0]           hum_gain,
    input  logic signed [sfcd_pkg::OFFSET_W-1:0]  temp_offset,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [7:0]                            m_status_byte,
    output logic                                  m_crc_match,
    output logic [sfcd_pkg::RAW_W-1:0]            m_humidity_raw,
    output logic [sfcd_pkg::RAW_W-1:0]            m_raw_temperature,
    output logic [sfcd_pkg::HUM_Q8_W-1:0]         m_humidity_q8,
    output logic signed [sfcd_pkg::TMP_Q8_W-1:0]  m_temperature_q8
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int unsigned HP1 = sfcd_pkg::HUM_P1_W;
    localparam int unsigned HP2 = sfcd_pkg::HUM_P2_W;
    localparam int unsigned TP1 = sfcd_pkg::TMP_P1_W;
    localparam int unsigned TQW = sfcd_pkg::TMP_Q8_W;

    logic [1:0]                  state_reg, state_next;
    sfcd_pkg::frame_t            frame_reg;
    logic [HP1-1:0]              hum_p1_reg;
    logic [TP1-1:0]              tmp_p1_reg;
    logic [HP2-1:0]              hum_p2_reg;
    logic signed [TQW-1:0]       tmp_q8_reg;
    logic                        m_valid_reg, m_valid_next;
    logic                        load_out;
    logic signed [TQW:0]         tmp_sum;

    assign m_valid = m_valid_reg;

    // floor(raw*200 / 2^12) - 50 degC + offset, all in Q8
    assign tmp_sum = $signed({2'b00, tmp_p1_reg[TP1-1:sfcd_pkg::TMP_SHIFT]})
                   - $signed((TQW+1)'(sfcd_pkg::TMP_BIAS))
                   + $signed({{(TQW+1-sfcd_pkg::OFFSET_W){temp_offset[sfcd_pkg::OFFSET_W-1]}},
                              temp_offset});

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = load_out ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            frame_reg <= q_frame;
        end
        if (state_reg == ST_MUL1) begin
            hum_p1_reg <= HP1'(frame_reg.humidity_raw) * HP1'(sfcd_pkg::HUM_SCALE);
            tmp_p1_reg <= TP1'(frame_reg.raw_temperature) * TP1'(sfcd_pkg::TMP_SCALE);
        end
        if (state_reg == ST_MUL2) begin
            hum_p2_reg <= HP2'(hum_p1_reg) * HP2'(hum_gain);
            tmp_q8_reg <= tmp_sum[TQW-1:0];
        end
        if (load_out) begin
            m_status_byte     <= frame_reg.status_byte;
            m_crc_match       <= frame_reg.crc_match;
            m_humidity_raw    <= frame_reg.humidity_raw;
            m_raw_temperature <= frame_reg.raw_temperature;
            m_humidity_q8     <= hum_p2_reg[HP2-1:sfcd_pkg::HUM_SHIFT];
            m_temperature_q8  <= tmp_q8_reg;
        end
    end

endmodule
